/* sv/scytale_transposition_core_defines.svh */
// Assertion macros shared by the scytale checker.
`ifndef SCYTALE_TRANSPOSITION_CORE_DEFINES_SVH
`define SCYTALE_TRANSPOSITION_CORE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, quiet while i_rst_n is low.
`define SCYT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scytale checker: same-cycle rule broken");

// Next-cycle implication, clocked on i_clk, quiet while i_rst_n is low.
`define SCYT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scytale checker: next-cycle rule broken");

`endif

/* sv/scyt_pkg.sv */
// Shared types and constants of the scytale transposition block.
package scyt_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int BYTE_W      = 8;
    localparam int CELL_W      = 6;   // key, grid cell index, rows, counts
    localparam int ACC_W       = 7;   // rows * key accumulator
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD  = 2'd2;

    localparam logic [CELL_W-1:0] KEY_RST = 6'd4;
    localparam logic [BYTE_W-1:0] PAD_RST = 8'd120;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_KEY   = 2'd1;
    localparam t_status ST_OVF   = 2'd2;
    localparam t_status ST_EMPTY = 2'd3;

    // Store access from the sequencer: one write and one read port.
    typedef struct packed {
        logic              wr_en;
        logic [CELL_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [CELL_W-1:0] rd_addr;
    } t_store_req;

endpackage

/* sv/scyt_ifs.sv */
// Request channel interfaces of the scytale block: message in, result out.
interface scyt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface scyt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;

    modport source (output valid, output out_byte, output out_last, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input status,
                    output ready);
endinterface

/* sv/scyt_store.sv */
// Message store: single-port write, registered read.
module scyt_store import scyt_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  t_store_req        i_req,
    output logic [BYTE_W-1:0] o_rd_data
);

    localparam int ADDR_W = $clog2(MAX_LEN);

    logic [BYTE_W-1:0] r_mem [MAX_LEN];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[ADDR_W-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[ADDR_W-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/scyt_seq.sv */
// Load, grid walk and result sequencer with its output register.
module scyt_seq import scyt_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CELL_W-1:0] i_column_key,
    input  logic              i_decrypt_mode,
    input  logic [BYTE_W-1:0] i_pad_byte,
    scyt_in_if.sink           i_in,
    scyt_out_if.source        o_out,
    output t_store_req        o_req,
    input  logic [BYTE_W-1:0] i_rd_data
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_CHECK, S_ROWS, S_SCAN_RD, S_SCAN_CHK, S_SCAN_END,
        S_EMIT_RD, S_EMIT_WR, S_ERR
    } t_state;

    t_state            r_state;
    logic [LEN_W-1:0]  r_len;
    logic              r_ovf;
    t_status           r_err;
    logic [ACC_W-1:0]  r_acc;
    logic [CELL_W-1:0] r_rows;
    logic [CELL_W-1:0] r_outer;
    logic [CELL_W-1:0] r_inner;
    logic [CELL_W-1:0] r_k;
    logic [CELL_W-1:0] r_idx;
    logic [CELL_W-1:0] r_cnt;
    logic              r_in_range;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    t_status           r_out_status;

    logic              in_acc;
    logic              has_room;
    logic [CELL_W-1:0] len_ext;
    logic [CELL_W-1:0] lim_o;
    logic [CELL_W-1:0] lim_i;
    logic [CELL_W-1:0] stride;
    logic              wrap_i;
    logic              last_cell;
    logic [CELL_W-1:0] n_outer;
    logic [CELL_W-1:0] n_inner;
    logic [CELL_W-1:0] n_k;
    logic [BYTE_W-1:0] cell_val;
    logic              out_free;
    logic              out_load;
    logic              emit_last;

    assign in_acc    = i_in.valid && (r_state == S_LOAD);
    assign has_room  = r_len < LEN_W'(MAX_LEN);
    assign len_ext   = CELL_W'(r_len);

    // encrypt: outer = column, inner = row; decrypt: the other way round
    assign lim_o     = i_decrypt_mode ? r_rows : i_column_key;
    assign lim_i     = i_decrypt_mode ? i_column_key : r_rows;
    assign stride    = i_decrypt_mode ? r_rows : i_column_key;
    assign wrap_i    = (r_inner == lim_i - 1'b1);
    assign last_cell = wrap_i && (r_outer == lim_o - 1'b1);

    always_comb begin
        if (wrap_i) begin
            n_inner = '0;
            n_outer = r_outer + 1'b1;
            n_k     = r_outer + 1'b1;
        end else begin
            n_inner = r_inner + 1'b1;
            n_outer = r_outer;
            n_k     = r_k + stride;
        end
    end

    assign cell_val  = r_in_range ? i_rd_data : i_pad_byte;
    assign out_free  = !r_out_valid || o_out.ready;
    assign out_load  = out_free && ((r_state == S_EMIT_WR) || (r_state == S_ERR));
    assign emit_last = ((r_idx + 1'b1) == r_cnt);

    always_comb begin
        o_req.wr_en   = in_acc && has_room;
        o_req.wr_addr = len_ext;
        o_req.wr_data = i_in.in_byte;
        o_req.rd_en   = (r_state == S_SCAN_RD) || (r_state == S_EMIT_RD);
        o_req.rd_addr = r_k;
    end

    assign i_in.ready     = (r_state == S_LOAD);
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.out_last = r_out_last;
    assign o_out.status   = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (has_room) begin
                            r_len <= r_len + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.in_last) begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_ovf) begin
                        r_err   <= ST_OVF;
                        r_state <= S_ERR;
                    end else if ((i_column_key == '0) ||
                                 (!i_decrypt_mode && (i_column_key >= len_ext))) begin
                        r_err   <= ST_KEY;
                        r_state <= S_ERR;
                    end else begin
                        r_acc   <= ACC_W'(i_column_key);
                        r_rows  <= CELL_W'(1);
                        r_state <= S_ROWS;
                    end
                end
                S_ROWS: begin
                    // rows = ceil(n / key) by repeated addition; r_acc ends at rows * key
                    if (r_acc >= ACC_W'(r_len)) begin
                        r_outer <= '0;
                        r_inner <= '0;
                        r_k     <= '0;
                        r_idx   <= '0;
                        r_cnt   <= i_decrypt_mode ? '0 : r_acc[CELL_W-1:0];
                        r_state <= i_decrypt_mode ? S_SCAN_RD : S_EMIT_RD;
                    end else begin
                        r_acc  <= r_acc + ACC_W'(i_column_key);
                        r_rows <= r_rows + 1'b1;
                    end
                end
                S_SCAN_RD: begin
                    r_in_range <= (r_k < len_ext);
                    r_state    <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    // keep the count up to the last cell that is not pad
                    if (cell_val != i_pad_byte) begin
                        r_cnt <= r_idx + 1'b1;
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_outer <= n_outer;
                    r_inner <= n_inner;
                    r_k     <= n_k;
                    r_state <= last_cell ? S_SCAN_END : S_SCAN_RD;
                end
                S_SCAN_END: begin
                    if (r_cnt == '0) begin
                        r_err   <= ST_EMPTY;
                        r_state <= S_ERR;
                    end else begin
                        r_outer <= '0;
                        r_inner <= '0;
                        r_k     <= '0;
                        r_idx   <= '0;
                        r_state <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD: begin
                    r_in_range <= (r_k < len_ext);
                    r_state    <= S_EMIT_WR;
                end
                S_EMIT_WR: begin
                    // read data holds while waiting: no read issued here
                    if (out_free) begin
                        r_out_byte   <= cell_val;
                        r_out_last   <= emit_last;
                        r_out_status <= ST_OK;
                        if (emit_last) begin
                            r_len   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_outer <= n_outer;
                            r_inner <= n_inner;
                            r_k     <= n_k;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_out_byte   <= '0;
                        r_out_last   <= 1'b1;
                        r_out_status <= r_err;
                        r_len        <= '0;
                        r_ovf        <= 1'b0;
                        r_state      <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

/* sv/scytale_transposition_core.sv */
// Top level of the scytale columnar transposition block.
//
//  channel  dir  handshake        payload
//  i_in     in   valid / ready    in_byte[7:0], in_last
//  o_out    out  valid / ready    out_byte[7:0], out_last, status[1:0]
//  i_cfg    in   i_cfg_we only    i_cfg_idx[1:0], i_cfg_data[7:0]
//
// Loading takes one byte a cycle into the message store. After the last
// byte the sequencer works out rows by repeated addition, one add per row,
// then walks the grid through the store's single read port, each cell by a
// read and then the registered data. Decrypt walks the grid twice, once
// to find the last byte that is not pad and once to emit. No request is
// taken on i_in from the last byte until the final result enters the output
// register; o_out stalls hold the walk. Reset is synchronous, active low,
// and clears control only; the store holds nothing valid after reset.
module scytale_transposition_core import scyt_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    scyt_in_if.sink               i_in,
    scyt_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers; the user must write them only while the block is idle (not enforced by the block)
    logic [CELL_W-1:0] r_column_key;
    logic              r_decrypt_mode;
    logic [BYTE_W-1:0] r_pad_byte;

    t_store_req        store_req;
    logic [BYTE_W-1:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_key   <= KEY_RST;
            r_decrypt_mode <= 1'b0;
            r_pad_byte     <= PAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY:  r_column_key   <= i_cfg_data[CELL_W-1:0];
                CFG_MODE: r_decrypt_mode <= i_cfg_data[0];
                CFG_PAD:  r_pad_byte     <= i_cfg_data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // the store is written only while loading and read only while draining,
    // so the ports never touch the same entry in one cycle
    scyt_store #(
        .MAX_LEN (MAX_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    scyt_seq #(
        .MAX_LEN (MAX_LEN)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_column_key   (r_column_key),
        .i_decrypt_mode (r_decrypt_mode),
        .i_pad_byte     (r_pad_byte),
        .i_in           (i_in),
        .o_out          (o_out),
        .o_req          (store_req),
        .i_rd_data      (rd_data)
    );

endmodule

/* sv/scyt_checker.sv */
// Port-level assertions for the scytale block and their bind.
`include "scytale_transposition_core_defines.svh"

module scyt_checker import scyt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_last,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] i_out_byte,
    input logic              i_out_last,
    input t_status           i_out_status
);

    logic [BYTE_W+2:0] out_payload;
    logic              out_wait;
    logic              out_err;

    assign out_payload = {i_out_byte, i_out_last, i_out_status};
    assign out_wait    = i_out_valid && !i_out_ready;
    assign out_err     = i_out_valid && (i_out_status != ST_OK);

    `SCYT_ASSERT_NEXT(a_out_held, out_wait, i_out_valid)
    `SCYT_ASSERT_NEXT(a_out_stable, out_wait, $stable(out_payload))
    `SCYT_ASSERT_NOW(a_err_final, out_err, i_out_last && (i_out_byte == '0))
    `SCYT_ASSERT_NEXT(a_drain_closed, i_in_valid && i_in_ready && i_in_last, !i_in_ready)

endmodule

bind scytale_transposition_core scyt_checker u_scyt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_last    (i_in.in_last),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_out_last   (o_out.out_last),
    .i_out_status (o_out.status)
);

/* test/scytale_transposition_core_test.sv */
// Self-checking testbench of the scytale columnar transposition block.
module scytale_transposition_core_test;
    import scyt_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_SETTLE  = 40;    // quiet cycles before a register write
    localparam int END_SETTLE    = 400;   // quiet cycles after the last phase
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 24;
    localparam int GRID_CELLS    = 63;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_plain_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        t_status           status;
    } t_cipher_byte;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    scyt_in_if  in_ch ();
    scyt_out_if out_ch ();

    scytale_transposition_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Mirror of the block's registers and message store.
    logic [CELL_W-1:0] key_setting;
    logic              decrypt_setting;
    logic [BYTE_W-1:0] pad_setting;
    logic [BYTE_W-1:0] msg_store [0:MAX_LEN_DEF-1];
    int                msg_len;
    logic              msg_overflow;

    t_plain_item  plain_pending [$];
    t_cipher_byte expected_cipher [$];
    t_plain_item  current_item;
    int           in_issued;
    int           in_accepted;
    int           items_queued;
    int           error_count;
    int           cycle_count;
    logic         no_idle;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic flag_error(input string msg);
        $display("mismatch @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Works out the transposed bytes that one accepted request causes.
    task automatic transpose_step(input logic [BYTE_W-1:0] b, input logic last);
        logic [BYTE_W-1:0] grid [0:GRID_CELLS];
        int               n;
        int               cols;
        int               rows;
        int               cnt;
        int               k;
        t_status          err;
        t_cipher_byte     res;
        if (msg_len < MAX_LEN_DEF) begin
            msg_store[msg_len] = b;
            msg_len++;
        end else begin
            msg_overflow = 1'b1;
        end
        if (last) begin
            n    = msg_len;
            cols = int'(key_setting);
            cnt  = 0;
            err  = ST_OK;
            if (msg_overflow) begin
                err = ST_OVF;
            end else if (cols == 0 || (!decrypt_setting && cols >= n)) begin
                err = ST_KEY;
            end else begin
                rows = (n + cols - 1) / cols;
                if (!decrypt_setting) begin
                    for (int c = 0; c < cols; c++)
                        for (int r = 0; r < rows; r++) begin
                            k = r * cols + c;
                            if (cnt < GRID_CELLS) begin
                                grid[cnt] = (k < n) ? msg_store[k] : pad_setting;
                                cnt++;
                            end
                        end
                end else begin
                    for (int r = 0; r < rows; r++)
                        for (int c = 0; c < cols; c++) begin
                            k = c * rows + r;
                            if (cnt < GRID_CELLS) begin
                                grid[cnt] = (k < n) ? msg_store[k] : pad_setting;
                                cnt++;
                            end
                        end
                    while (cnt > 0 && grid[cnt-1] == pad_setting)
                        cnt--;
                end
                if (cnt == 0)
                    err = ST_EMPTY;
            end
            if (err != ST_OK) begin
                res.data   = '0;
                res.last   = 1'b1;
                res.status = err;
                expected_cipher.insert(expected_cipher.size(), res);
            end else begin
                for (int i = 0; i < cnt; i++) begin
                    res.data   = grid[i];
                    res.last   = (i + 1 == cnt);
                    res.status = ST_OK;
                    expected_cipher.insert(expected_cipher.size(), res);
                end
            end
            msg_len      = 0;
            msg_overflow = 1'b0;
        end
    endtask

    // Sampling at the rising edge: results first, then the accepted request.
    always @(posedge i_clk) begin : monitor
        t_cipher_byte got;
        t_cipher_byte want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.data   = out_ch.out_byte;
                got.last   = out_ch.out_last;
                got.status = out_ch.status;
                if (expected_cipher.size() == 0) begin
                    flag_error($sformatf("unexpected result byte %02h last %0b status %0d",
                                         got.data, got.last, got.status));
                end else begin
                    want = expected_cipher.pop_front();
                    if (got.data !== want.data || got.last !== want.last ||
                        got.status !== want.status)
                        flag_error($sformatf(
                            "got byte %02h last %0b status %0d, want %02h %0b %0d",
                            got.data, got.last, got.status,
                            want.data, want.last, want.status));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                transpose_step(in_ch.in_byte, in_ch.in_last);
                in_accepted++;
            end
        end
    end

    // Inputs change at the falling edge; a raised valid holds until taken.
    always @(negedge i_clk) begin : driver
        logic gap;
        logic stall;
        gap   = !no_idle && ($urandom_range(99) < 6);
        stall = !no_idle && ($urandom_range(99) < 6);
        if (i_rst_n) begin
            if (in_issued == in_accepted && plain_pending.size() > 0 && !gap) begin
                current_item = plain_pending.pop_front();
                in_issued++;
            end
            in_ch.valid   <= (in_issued != in_accepted);
            in_ch.in_byte <= current_item.data;
            in_ch.in_last <= current_item.last;
            out_ch.ready  <= !stall;
        end
    end

    task automatic add_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_plain_item item;
        item.data = b;
        item.last = last;
        plain_pending.insert(plain_pending.size(), item);
        items_queued++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], i == s.len() - 1);
    endtask

    // Mostly in-range lengths, a few past capacity; pad bytes are common so
    // that stripping and all-pad messages come up.
    task automatic send_random_message();
        int   len;
        int   pick;
        logic all_pad;
        pick    = $urandom_range(99);
        all_pad = ($urandom_range(99) < 5);
        if (pick < 8)
            len = $urandom_range(MAX_LEN_DEF + 3, MAX_LEN_DEF + 1);
        else if (pick < 20)
            len = $urandom_range(3, 1);
        else
            len = $urandom_range(MAX_LEN_DEF, 1);
        for (int i = 0; i < len; i++)
            add_byte((all_pad || $urandom_range(99) < 20) ? pad_setting
                                                        : BYTE_W'($urandom_range(255)),
                     i == len - 1);
    endtask

    task automatic wait_drained(input int settle);
        while (plain_pending.size() != 0 || in_issued != in_accepted ||
               expected_cipher.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            CFG_KEY:  key_setting     = value[CELL_W-1:0];
            CFG_MODE: decrypt_setting = value[0];
            CFG_PAD:  pad_setting     = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CELL_W-1:0] key, input logic mode,
                             input logic [BYTE_W-1:0] pad);
        write_register(CFG_KEY, CFG_DATA_W'(key));
        write_register(CFG_MODE, CFG_DATA_W'(mode));
        write_register(CFG_PAD, pad);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : timeout
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [CELL_W-1:0] key;
        in_ch.valid     = 1'b0;
        in_ch.in_byte   = '0;
        in_ch.in_last   = 1'b0;
        out_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        i_rst_n         = 1'b0;
        key_setting     = KEY_RST;
        decrypt_setting = 1'b0;
        pad_setting     = PAD_RST;
        msg_len         = 0;
        msg_overflow    = 1'b0;
        in_issued       = 0;
        in_accepted     = 0;
        items_queued    = 0;
        error_count     = 0;
        cycle_count     = 0;
        no_idle         = 1'b0;
        current_item    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: key 4, encrypt, pad 'x'. Byte extremes, a padded
        // grid, then keys not below the length.
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        send_text("SCYTA");
        send_text("Q");
        send_text("WXYZ");
        wait_drained(PHASE_SETTLE);

        // Zero key.
        configure(6'd0, 1'b0, 8'h78);
        send_text("AB");
        wait_drained(PHASE_SETTLE);

        // Decrypt with key above length, an all-pad message, trailing pads.
        configure(6'd5, 1'b1, 8'h2E);
        send_text("ab");
        send_text("..");
        send_text("a.b..");
        wait_drained(PHASE_SETTLE);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            key = ($urandom_range(99) < 15) ? CELL_W'($urandom_range(32, 10))
                                            : CELL_W'($urandom_range(9, 1));
            case (p)
                0:       configure(6'd1, 1'b0, 8'h00);
                1:       configure(6'd32, 1'b1, 8'hFF);
                2:       configure(6'd63, 1'b1, BYTE_W'($urandom_range(255)));
                3:       configure(6'd2, 1'b0, BYTE_W'($urandom_range(255)));
                4:       configure(6'd0, 1'b1, BYTE_W'($urandom_range(255)));
                5:       configure(6'd31, 1'b0, BYTE_W'($urandom_range(255)));
                default: configure(key, 1'($urandom_range(1)),
                                   BYTE_W'($urandom_range(255)));
            endcase
            // One phase runs with both sides at full rate.
            no_idle = (p == 3);
            begin : fill_phase
                int target;
                target = items_queued + PHASE_ITEMS;
                while (items_queued < target)
                    send_random_message();
            end
            // The sender holds off here until every result has come back.
            wait_drained(PHASE_SETTLE);
        end
        no_idle = 1'b0;

        wait_drained(END_SETTLE);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/scyt_pkg.sv
sv/scyt_ifs.sv
sv/scyt_store.sv
sv/scyt_seq.sv
sv/scytale_transposition_core.sv
sv/scyt_checker.sv
test/scytale_transposition_core_test.sv
